### rtl/sfdl_pkg.sv
// Package with constants, types and helper functions of the stereo feedback delay line.
`timescale 1ns / 1ps
package sfdl_pkg;

  localparam int unsigned DEPTH        = 65536;
  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned ADDR_W       = $clog2(DEPTH);
  localparam int unsigned FRAC_W       = 8;
  localparam int unsigned POS_W        = ADDR_W + FRAC_W;

  localparam int unsigned WET_W        = 16;
  localparam int unsigned FB_W         = 15;
  localparam int unsigned TARGET_W     = 24;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 24;

  localparam int unsigned SMOOTH_ALIGN = 12;
  localparam int unsigned SMOOTH_W     = TARGET_W + SMOOTH_ALIGN;
  localparam int unsigned SMOOTH_NUM   = 4194;
  localparam int unsigned SMOOTH_SHIFT = 22;
  localparam int unsigned Q15_SHIFT    = 15;

  localparam int unsigned MUL_A_W      = SMOOTH_W + 1;
  localparam int unsigned MUL_B_W      = 18;
  localparam int unsigned PROD_W       = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W        = PROD_W + 1;

  localparam logic [WET_W-1:0]    WET_RESET    = WET_W'(16384);
  localparam logic [FB_W-1:0]     FB_RESET     = FB_W'(16384);
  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(6144000);

  localparam logic [FRAC_W:0]      FRAC_ONE = (FRAC_W + 1)'(256);
  localparam logic [MUL_B_W-1:0]   WET_ONE  = MUL_B_W'(32768);

  localparam logic signed [ACC_W-1:0] RND_INTERP = ACC_W'(128);
  localparam logic signed [ACC_W-1:0] RND_Q15    = ACC_W'(16384);

  localparam logic signed [ACC_W-1:0] SAMPLE_MAX =
    $signed({{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAMPLE_MIN =
    $signed({{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}});

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WET_GAIN      = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_DELAY_TARGET  = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_GLIDE,
    ST_ADDR,
    ST_RD_A,
    ST_MUL_A,
    ST_MUL_B,
    ST_FEEDBACK,
    ST_MIX_DRY,
    ST_MIX_WET,
    ST_DONE
  } state_e;

  function automatic logic signed [ACC_W-1:0] sext_sample(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    return $signed({{(ACC_W - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s});
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SAMPLE_MAX) begin
      r = $signed({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
    end else if (v < SAMPLE_MIN) begin
      r = $signed({1'b1, {(SAMPLE_BITS - 1){1'b0}}});
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/stereo_feedback_delay_line.sv
// Stereo feedback delay line with gliding fractional delay and one shared multiply-accumulate.
//
//  Channel  | Signals                                   | Request
//  ---------+-------------------------------------------+----------------------------
//  input    | in_valid_i, in_ready_o                    | left_in_i, right_in_i
//  output   | out_valid_o, out_ready_i                  | left_out_o, right_out_o
//  config   | cfg_we_i, cfg_index_i                     | cfg_data_i
//
// Before its result is offered, an accepted request passes in turn through the one
// multiply-accumulate unit that serves the glide, both interpolations, feedback and mixes.
// The result waits in an output register, so the next request can be accepted meanwhile.
// Reset clears the control state; the delay stores need no clearing pass, as entries not
// yet written since reset read as zero through the write position and a wrap flag.
// A stalled output holds the second channel's final step until the register is free.
`timescale 1ns / 1ps
module stereo_feedback_delay_line (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [sfdl_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [sfdl_pkg::CFG_DATA_W-1:0]             cfg_data_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic signed [sfdl_pkg::SAMPLE_BITS-1:0]     left_in_i,
  input  logic signed [sfdl_pkg::SAMPLE_BITS-1:0]     right_in_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic signed [sfdl_pkg::SAMPLE_BITS-1:0]     left_out_o,
  output logic signed [sfdl_pkg::SAMPLE_BITS-1:0]     right_out_o
);
  import sfdl_pkg::*;

  state_e state_q, state_d;

  logic [WET_W-1:0]    wet_q;
  logic [FB_W-1:0]     fb_gain_q;
  logic [TARGET_W-1:0] target_q;

  logic [ADDR_W-1:0]   wp_q;
  logic                wrapped_q;
  logic                primed_q;
  logic [SMOOTH_W-1:0] smoothed_q;
  logic                chan_q;
  logic                out_valid_q;

  logic signed [SAMPLE_BITS-1:0] fb_l_q, fb_r_q;
  logic signed [SAMPLE_BITS-1:0] in_l_q, in_r_q;
  logic signed [SAMPLE_BITS-1:0] d_q;
  logic signed [SAMPLE_BITS-1:0] res_l_q;
  logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;
  logic [ADDR_W-1:0]             ia_q;
  logic [FRAC_W-1:0]             f_q;
  logic signed [ACC_W-1:0]       acc_q, acc_d;

  logic signed [SAMPLE_BITS-1:0] left_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] right_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_l_q, rd_r_q;
  logic                          rvalid_q;

  logic                          mem_we, mem_re, rvalid_d;
  logic [ADDR_W-1:0]             raddr;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      product;
  logic signed [ACC_W-1:0]       product_ext;
  logic signed [ACC_W-1:0]       acc_sh8, acc_sh15, acc_sh22, glide_sum;
  logic signed [SAMPLE_BITS-1:0] wdata_l, wdata_r, rdat, in_c, d_now, res_now;
  logic [SMOOTH_W-1:0]           target_ext;
  logic signed [MUL_A_W-1:0]     diff;
  logic [POS_W-1:0]              pos;
  logic                          in_acc, finish;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

  assign target_ext  = {target_q, {SMOOTH_ALIGN{1'b0}}};
  assign diff        = $signed({1'b0, target_ext}) - $signed({1'b0, smoothed_q});
  assign pos         = {wp_q, {FRAC_W{1'b0}}} - POS_W'(smoothed_q >> SMOOTH_ALIGN);

  assign product     = mul_a * mul_b;
  assign product_ext = {product[PROD_W-1], product};
  assign acc_sh8     = acc_q >>> FRAC_W;
  assign acc_sh15    = acc_q >>> Q15_SHIFT;
  assign acc_sh22    = acc_q >>> SMOOTH_SHIFT;
  assign glide_sum   = $signed({{(ACC_W - SMOOTH_W){1'b0}}, smoothed_q}) + acc_sh22;

  assign wdata_l     = sat_sample(sext_sample(in_l_q) + sext_sample(fb_l_q));
  assign wdata_r     = sat_sample(sext_sample(in_r_q) + sext_sample(fb_r_q));
  assign rdat        = !rvalid_q ? '0 : (chan_q ? rd_r_q : rd_l_q);
  assign in_c        = chan_q ? in_r_q : in_l_q;
  assign d_now       = acc_sh8[SAMPLE_BITS-1:0];
  assign res_now     = sat_sample(acc_sh15);
  assign finish      = (state_q == ST_DONE) && chan_q && (!out_valid_q || out_ready_i);
  assign rvalid_d    = wrapped_q || (raddr <= wp_q);

  always_comb begin
    state_d = state_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    raddr   = ia_q;
    mul_a   = '0;
    mul_b   = '0;
    acc_d   = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we  = 1'b1;
        mul_a   = diff;
        mul_b   = MUL_B_W'(SMOOTH_NUM);
        acc_d   = product_ext;
        state_d = ST_GLIDE;
      end
      ST_GLIDE: begin
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        state_d = ST_RD_A;
      end
      ST_RD_A: begin
        mem_re  = 1'b1;
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        mem_re  = 1'b1;
        raddr   = ia_q + ADDR_W'(1);
        mul_a   = $signed({{(MUL_A_W - SAMPLE_BITS){rdat[SAMPLE_BITS-1]}}, rdat});
        mul_b   = $signed(MUL_B_W'(FRAC_ONE - {1'b0, f_q}));
        acc_d   = RND_INTERP + product_ext;
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        mul_a   = $signed({{(MUL_A_W - SAMPLE_BITS){rdat[SAMPLE_BITS-1]}}, rdat});
        mul_b   = $signed(MUL_B_W'(f_q));
        acc_d   = acc_q + product_ext;
        state_d = ST_FEEDBACK;
      end
      ST_FEEDBACK: begin
        mul_a   = $signed({{(MUL_A_W - SAMPLE_BITS){d_now[SAMPLE_BITS-1]}}, d_now});
        mul_b   = $signed(MUL_B_W'(fb_gain_q));
        acc_d   = RND_Q15 + product_ext;
        state_d = ST_MIX_DRY;
      end
      ST_MIX_DRY: begin
        mul_a   = $signed({{(MUL_A_W - SAMPLE_BITS){in_c[SAMPLE_BITS-1]}}, in_c});
        mul_b   = $signed(WET_ONE - MUL_B_W'(wet_q));
        acc_d   = RND_Q15 + product_ext;
        state_d = ST_MIX_WET;
      end
      ST_MIX_WET: begin
        mul_a   = $signed({{(MUL_A_W - SAMPLE_BITS){d_q[SAMPLE_BITS-1]}}, d_q});
        mul_b   = $signed(MUL_B_W'(wet_q));
        acc_d   = acc_q + product_ext;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!chan_q) begin
          state_d = ST_RD_A;
        end else if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_q       <= WET_RESET;
      fb_gain_q   <= FB_RESET;
      target_q    <= TARGET_RESET;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      primed_q    <= 1'b0;
      smoothed_q  <= '0;
      chan_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fb_l_q      <= '0;
      fb_r_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_WET_GAIN:      wet_q     <= cfg_data_i[WET_W-1:0];
          REG_FEEDBACK_GAIN: fb_gain_q <= cfg_data_i[FB_W-1:0];
          REG_DELAY_TARGET:  target_q  <= cfg_data_i[TARGET_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == ST_GLIDE) begin
        smoothed_q <= primed_q ? glide_sum[SMOOTH_W-1:0] : target_ext;
        primed_q   <= 1'b1;
      end
      if (state_q == ST_MIX_DRY) begin
        if (chan_q) begin
          fb_r_q <= acc_sh15[SAMPLE_BITS-1:0];
        end else begin
          fb_l_q <= acc_sh15[SAMPLE_BITS-1:0];
        end
      end
      if ((state_q == ST_DONE) && !chan_q) begin
        chan_q <= 1'b1;
      end
      if (finish) begin
        chan_q      <= 1'b0;
        out_valid_q <= 1'b1;
        wp_q        <= wp_q + ADDR_W'(1);
        if (wp_q == ADDR_W'(DEPTH - 1)) begin
          wrapped_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_acc) begin
      in_l_q <= left_in_i;
      in_r_q <= right_in_i;
    end
    if (state_q == ST_ADDR) begin
      ia_q <= pos[POS_W-1:FRAC_W];
      f_q  <= pos[FRAC_W-1:0];
    end
    if (state_q == ST_FEEDBACK) begin
      d_q <= d_now;
    end
    if ((state_q == ST_DONE) && !chan_q) begin
      res_l_q <= res_now;
    end
    if (finish) begin
      left_out_q  <= res_l_q;
      right_out_q <= res_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      left_mem[wp_q]  <= wdata_l;
      right_mem[wp_q] <= wdata_r;
    end
    if (mem_re) begin
      rd_l_q   <= left_mem[raddr];
      rd_r_q   <= right_mem[raddr];
      rvalid_q <= rvalid_d;
    end
  end

endmodule
